/* design/swmd_pkg.sv */
// shared types and constants for the sliding window median deviation block
`timescale 1ns / 1ps

package swmd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int CFG_BITS    = 7;
    localparam int MEDIAN_BITS = 16;
    localparam int COST_BITS   = 22;
    localparam int BEST_BITS   = 23;

    localparam logic [CFG_BITS-1:0]  WL_RESET  = 7'd8;
    localparam logic [BEST_BITS-1:0] BEST_INIT = {BEST_BITS{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RANK,
        ST_MEDIAN,
        ST_DEV,
        ST_SUM,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic shift;
        logic load_rank;
        logic rotate;
        logic count;
        logic load_dev;
    } t_cell_ctrl;

endpackage

/* design/swmd_if.sv */
// valid/ready channel interfaces for sample words and result words
`timescale 1ns / 1ps

interface swmd_in_if;
    import swmd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   end_of_sequence;

    modport source (output valid, output sample, output end_of_sequence, input ready);
    modport sink   (input valid, input sample, input end_of_sequence, output ready);
endinterface

interface swmd_out_if;
    import swmd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   window_full;
    logic [MEDIAN_BITS-1:0] window_median;
    logic [COST_BITS-1:0]   window_cost;
    logic [BEST_BITS-1:0]   best_cost;

    modport source (
        output valid, output window_full, output window_median,
        output window_cost, output best_cost, input ready
    );
    modport sink (
        input valid, input window_full, input window_median,
        input window_cost, input best_cost, output ready
    );
endinterface

/* design/swmd_cell.sv */
// one window cell: holds a sample, counts its rank and passes a travel word on
`timescale 1ns / 1ps

module swmd_cell #(
    parameter int IDX = 0,
    parameter int KW  = 7
) (
    input  logic                             i_clk,
    input  swmd_pkg::t_cell_ctrl             i_ctrl,
    input  logic [swmd_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [swmd_pkg::SAMPLE_BITS-1:0] i_travel,
    input  logic [KW-1:0]                    i_origin,
    input  logic [KW-1:0]                    i_k,
    input  logic [KW-1:0]                    i_target,
    input  logic [swmd_pkg::SAMPLE_BITS-1:0] i_median,
    output logic [swmd_pkg::SAMPLE_BITS-1:0] o_sample,
    output logic [swmd_pkg::SAMPLE_BITS-1:0] o_travel,
    output logic [KW-1:0]                    o_origin,
    output logic [swmd_pkg::SAMPLE_BITS-1:0] o_pick
);
    import swmd_pkg::*;

    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SAMPLE_BITS-1:0] r_travel;
    logic [KW-1:0]          r_origin;
    logic [KW-1:0]          r_rank;

    logic [SAMPLE_BITS-1:0] n_sample;
    logic                   w_in_window;
    logic                   w_below;
    logic [SAMPLE_BITS-1:0] w_dev;

    assign n_sample    = i_ctrl.shift ? i_sample : r_sample;
    assign w_in_window = KW'(IDX) < i_k;
    // stable order: ties broken by position so every rank is distinct
    assign w_below     = (r_travel < r_sample) ||
                         ((r_travel == r_sample) && (r_origin < KW'(IDX)));
    assign w_dev       = (r_sample >= i_median) ? (r_sample - i_median)
                                                : (i_median - r_sample);

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        if (i_ctrl.load_rank) begin
            r_travel <= n_sample;
            r_origin <= KW'(IDX);
            r_rank   <= '0;
        end else if (i_ctrl.load_dev) begin
            r_travel <= w_in_window ? w_dev : '0;
        end else if (i_ctrl.rotate) begin
            r_travel <= i_travel;
            r_origin <= i_origin;
            if (i_ctrl.count && w_below) begin
                r_rank <= r_rank + 1'b1;
            end
        end
    end

    assign o_sample = r_sample;
    assign o_travel = r_travel;
    assign o_origin = r_origin;
    assign o_pick   = (w_in_window && (r_rank == i_target)) ? r_sample : '0;

endmodule

/* design/sliding_window_median_deviation.sv */
// top level: sliding window lower median and absolute deviation cost
//
// Sample words enter on i_in (valid/ready) with an end_of_sequence flag; one
// result word leaves on o_out for every sample word. i_cfg_we/i_cfg_wdata set
// the window length K (0 acts as 1, above MAX_WINDOW saturates); the user
// must write it only while the block is idle; the block does not enforce it.
// A row of MAX_WINDOW cells keeps the newest samples in arrival order. For a
// full window the cells rotate their values to count ranks, the median is
// picked, deviations are formed and rotated into one accumulator; a window
// that is not yet full goes straight to the result register. i_in.ready is
// high only while no item is in work, so the rotation loop sets the throughput.
// The result register holds one word: the next item is accepted while it
// waits, and a stalled receiver holds the following item in its last step.
// Reset clears the fill count, the lowest cost (all ones), the window length
// (8) and the result valid flag; sample cells and result fields are not cleared.
`timescale 1ns / 1ps

module sliding_window_median_deviation #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [swmd_pkg::CFG_BITS-1:0] i_cfg_wdata,
    swmd_in_if.sink                       i_in,
    swmd_out_if.source                    o_out
);
    import swmd_pkg::*;

    localparam int KW = $clog2(MAX_WINDOW + 1);
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    t_state                 r_state;
    t_state                 n_state;
    logic [CFG_BITS-1:0]    r_wl;
    logic [KW-1:0]          r_fill;
    logic                   r_full;
    logic                   r_eos;
    logic [KW-1:0]          r_step;
    logic [SAMPLE_BITS-1:0] r_median;
    logic [BEST_BITS-1:0]   r_acc;
    logic [BEST_BITS-1:0]   r_lowest;
    logic                   r_out_valid;
    logic                   r_out_full;
    logic [MEDIAN_BITS-1:0] r_out_median;
    logic [COST_BITS-1:0]   r_out_cost;
    logic [BEST_BITS-1:0]   r_out_best;

    t_cell_ctrl             w_ctrl;
    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_out_load;
    logic [KW-1:0]          w_k;
    logic [KW-1:0]          w_k_m1;
    logic [KW-1:0]          w_target;
    logic [KW-1:0]          w_fill_inc;
    logic                   w_will_fill;
    logic                   w_last_step;
    logic [SAMPLE_BITS-1:0] w_pick_or;
    logic [BEST_BITS-1:0]   w_min_cost;

    logic [SAMPLE_BITS-1:0] w_sample [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] w_travel [MAX_WINDOW];
    logic [KW-1:0]          w_origin [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] w_pick   [MAX_WINDOW];

    // effective window length
    always_comb begin
        if (r_wl == '0) begin
            w_k = KW'(1);
        end else if (32'(r_wl) > MAX_WINDOW) begin
            w_k = KW'(MAX_WINDOW);
        end else begin
            w_k = KW'(r_wl);
        end
    end

    assign w_k_m1      = w_k - 1'b1;
    assign w_target    = w_k_m1 >> 1;
    assign w_fill_inc  = (r_fill == KW'(MAX_WINDOW)) ? r_fill : r_fill + 1'b1;
    assign w_will_fill = w_fill_inc >= w_k;
    assign w_last_step = r_step == w_k_m1;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_min_cost  = (r_acc < r_lowest) ? r_acc : r_lowest;

    // cell row
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        logic [SAMPLE_BITS-1:0] w_cell_sample;
        logic [SAMPLE_BITS-1:0] w_cell_travel;
        logic [KW-1:0]          w_cell_origin;

        if (g == 0) begin : g_head
            assign w_cell_sample = i_in.sample;
            assign w_cell_travel = w_travel[w_k_m1[AW-1:0]];
            assign w_cell_origin = w_origin[w_k_m1[AW-1:0]];
        end else begin : g_body
            assign w_cell_sample = w_sample[g-1];
            assign w_cell_travel = w_travel[g-1];
            assign w_cell_origin = w_origin[g-1];
        end

        swmd_cell #(
            .IDX (g),
            .KW  (KW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl),
            .i_sample (w_cell_sample),
            .i_travel (w_cell_travel),
            .i_origin (w_cell_origin),
            .i_k      (w_k),
            .i_target (w_target),
            .i_median (r_median),
            .o_sample (w_sample[g]),
            .o_travel (w_travel[g]),
            .o_origin (w_origin[g]),
            .o_pick   (w_pick[g])
        );
    end

    always_comb begin
        w_pick_or = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            w_pick_or = w_pick_or | w_pick[i];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_will_fill ? ST_RANK : ST_WRITE;
                end
            end
            ST_RANK: begin
                if (w_last_step) begin
                    n_state = ST_MEDIAN;
                end
            end
            ST_MEDIAN: n_state = ST_DEV;
            ST_DEV:    n_state = ST_SUM;
            ST_SUM: begin
                if (w_last_step) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_ctrl           = '0;
        w_ctrl.shift     = w_accept;
        w_ctrl.load_rank = w_accept;
        w_out_load       = 1'b0;
        case (r_state)
            ST_RANK: begin
                w_ctrl.rotate = 1'b1;
                w_ctrl.count  = 1'b1;
            end
            ST_DEV:   w_ctrl.load_dev = 1'b1;
            ST_SUM:   w_ctrl.rotate   = 1'b1;
            ST_WRITE: w_out_load      = w_out_free;
            default: begin
            end
        endcase
    end

    assign i_in.ready = r_state == ST_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wl        <= WL_RESET;
            r_fill      <= '0;
            r_lowest    <= BEST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_wl <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_fill <= i_in.end_of_sequence ? '0 : w_fill_inc;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                if (r_eos) begin
                    r_lowest <= BEST_INIT;
                end else if (r_full) begin
                    r_lowest <= w_min_cost;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_full <= w_will_fill;
            r_eos  <= i_in.end_of_sequence;
            r_step <= '0;
        end
        case (r_state)
            ST_RANK: r_step <= w_last_step ? '0 : r_step + 1'b1;
            ST_MEDIAN: r_median <= w_pick_or;
            ST_DEV: begin
                r_acc  <= '0;
                r_step <= '0;
            end
            ST_SUM: begin
                r_acc  <= r_acc + BEST_BITS'(w_travel[0]);
                r_step <= r_step + 1'b1;
            end
            default: begin
            end
        endcase
        if (w_out_load) begin
            r_out_full   <= r_full;
            r_out_median <= r_full ? MEDIAN_BITS'(r_median) : '0;
            r_out_cost   <= r_full ? r_acc[COST_BITS-1:0] : '0;
            r_out_best   <= r_full ? w_min_cost : r_lowest;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.window_full   = r_out_full;
    assign o_out.window_median = r_out_median;
    assign o_out.window_cost   = r_out_cost;
    assign o_out.best_cost     = r_out_best;

    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != ST_IDLE)
        else $error("accepted word did not start work");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= KW'(MAX_WINDOW))
        else $error("fill count beyond window capacity");

    a_not_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_full |-> r_out_median == '0 && r_out_cost == '0)
        else $error("partial window result carries nonzero fields");

    a_sum_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SUM && w_last_step |=> r_state == ST_WRITE)
        else $error("sum pass did not end after k steps");

endmodule

/* tb/tb_sliding_window_median_deviation.sv */
// self-checking testbench for the sliding window median deviation block
`timescale 1ns / 1ps

module tb_sliding_window_median_deviation;
    import swmd_pkg::*;

    localparam int WINDOW_SLOTS = 64;
    localparam int DRAIN_CYCLES = 2 * WINDOW_SLOTS + 16;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_WORDS = 950;
    localparam int HOLD_CYCLES  = 400;
    localparam int PRINT_LIMIT  = 40;

    typedef enum {SHAPE_WIDE, SHAPE_NEAR, SHAPE_RAIL, SHAPE_FLAT} t_shape;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   eos;
    } t_sample_word;

    typedef struct packed {
        logic                   window_full;
        logic [MEDIAN_BITS-1:0] window_median;
        logic [COST_BITS-1:0]   window_cost;
        logic [BEST_BITS-1:0]   best_cost;
    } t_window_stats;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_BITS-1:0] i_cfg_wdata;

    swmd_in_if  sample_if ();
    swmd_out_if stats_if ();

    sliding_window_median_deviation #(
        .MAX_WINDOW(WINDOW_SLOTS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (sample_if),
        .o_out      (stats_if)
    );

    logic [SAMPLE_BITS-1:0] held_samples [WINDOW_SLOTS];
    int unsigned            held_count;
    int unsigned            write_slot;
    logic [BEST_BITS-1:0]   lowest_seq_cost;
    logic [CFG_BITS-1:0]    window_len_reg;

    t_sample_word  samples_to_send [$];
    t_window_stats stats_due [$];

    int unsigned   words_accepted;
    int unsigned   results_checked;
    int unsigned   error_count;
    int unsigned   cycle_count;
    int unsigned   send_gap;
    int unsigned   recv_stall;
    logic          sender_steady;
    logic          receiver_steady;
    logic          hold_results;
    t_sample_word  next_word;
    t_window_stats want;

    function automatic int unsigned clamp_window(input logic [CFG_BITS-1:0] len);
        if (len == 0) return 1;
        if (len > WINDOW_SLOTS) return WINDOW_SLOTS;
        return 32'(len);
    endfunction

    function automatic t_window_stats window_stats_step(input logic [SAMPLE_BITS-1:0] s,
                                                        input logic eos);
        t_window_stats          r;
        int unsigned            k;
        int unsigned            i;
        int unsigned            j;
        int unsigned            sum;
        logic [SAMPLE_BITS-1:0] v;
        logic [SAMPLE_BITS-1:0] med;
        logic [SAMPLE_BITS-1:0] ordered [WINDOW_SLOTS];
        r = '0;
        k = clamp_window(window_len_reg);
        held_samples[write_slot] = s;
        write_slot = (write_slot + 1) % WINDOW_SLOTS;
        if (held_count < WINDOW_SLOTS) held_count++;
        if (held_count >= k) begin
            for (i = 0; i < k; i++) begin
                v = held_samples[(write_slot + WINDOW_SLOTS - 1 - i) % WINDOW_SLOTS];
                j = i;
                while (j > 0 && ordered[j-1] > v) begin
                    ordered[j] = ordered[j-1];
                    j--;
                end
                ordered[j] = v;
            end
            med = ordered[(k - 1) / 2];
            sum = 0;
            for (i = 0; i < k; i++) begin
                if (ordered[i] >= med) sum += ordered[i] - med;
                else sum += med - ordered[i];
            end
            r.window_full   = 1'b1;
            r.window_median = med;
            r.window_cost   = sum[COST_BITS-1:0];
            if (sum < lowest_seq_cost) lowest_seq_cost = sum[BEST_BITS-1:0];
        end
        r.best_cost = lowest_seq_cost;
        if (eos) begin
            held_count      = 0;
            write_slot      = 0;
            lowest_seq_cost = BEST_INIT;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_LIMIT) $display("mismatch at result %0d: %s", results_checked, what);
    endtask

    task automatic push_word(input logic [SAMPLE_BITS-1:0] s, input logic eos);
        t_sample_word w;
        w.sample = s;
        w.eos    = eos;
        samples_to_send.push_back(w);
    endtask

    task automatic queue_sequence(input int unsigned len, input logic close);
        t_shape                 shape;
        logic [SAMPLE_BITS-1:0] base;
        logic [SAMPLE_BITS-1:0] s;
        int unsigned            n;
        shape = t_shape'($urandom_range(0, 3));
        base  = SAMPLE_BITS'($urandom_range(0, 16'hFFFF));
        for (n = 0; n < len; n++) begin
            case (shape)
                SHAPE_WIDE: s = SAMPLE_BITS'($urandom_range(0, 16'hFFFF));
                SHAPE_NEAR: s = base ^ SAMPLE_BITS'($urandom_range(0, 15));
                SHAPE_RAIL: s = $urandom_range(0, 1) ? {SAMPLE_BITS{1'b1}} : '0;
                default:    s = base;
            endcase
            push_word(s, close && (n == len - 1));
        end
    endtask

    task automatic wait_drained();
        while (samples_to_send.size() != 0 || sample_if.valid || stats_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window_length(input logic [CFG_BITS-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        window_len_reg = v;
    endtask

    initial begin
        i_clk                     = 1'b0;
        i_rst_n                   = 1'b0;
        sample_if.valid           = 1'b0;
        sample_if.sample          = '0;
        sample_if.end_of_sequence = 1'b0;
        stats_if.ready            = 1'b0;
        held_count                = 0;
        write_slot                = 0;
        lowest_seq_cost           = BEST_INIT;
        window_len_reg            = WL_RESET;
        words_accepted            = 0;
        results_checked           = 0;
        error_count               = 0;
        cycle_count               = 0;
        send_gap                  = 0;
        recv_stall                = 0;
        fork
            forever #4 i_clk = ~i_clk;
            begin
                repeat (4) @(posedge i_clk);
                i_rst_n <= 1'b1;
            end
        join
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // sender: one word per handshake, random gap drawn per word unless steady
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sample_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (sample_if.valid && sample_if.ready) begin
                stats_due.push_back(window_stats_step(sample_if.sample,
                                                      sample_if.end_of_sequence));
                words_accepted++;
            end
            if (!sample_if.valid || sample_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    sample_if.valid <= 1'b0;
                end else if (samples_to_send.size() > 0) begin
                    next_word = samples_to_send.pop_front();
                    sample_if.valid           <= 1'b1;
                    sample_if.sample          <= next_word.sample;
                    sample_if.end_of_sequence <= next_word.eos;
                    send_gap = sender_steady ? 0 : $urandom_range(0, 11);
                end else begin
                    sample_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stats_if.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (stats_if.valid && stats_if.ready) begin
                if (stats_due.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = stats_due.pop_front();
                    if (stats_if.window_full !== want.window_full)
                        report_mismatch($sformatf("window_full got %b want %b",
                                                  stats_if.window_full, want.window_full));
                    if (stats_if.window_median !== want.window_median)
                        report_mismatch($sformatf("window_median got %0d want %0d",
                                                  stats_if.window_median, want.window_median));
                    if (stats_if.window_cost !== want.window_cost)
                        report_mismatch($sformatf("window_cost got %0d want %0d",
                                                  stats_if.window_cost, want.window_cost));
                    if (stats_if.best_cost !== want.best_cost)
                        report_mismatch($sformatf("best_cost got %0d want %0d",
                                                  stats_if.best_cost, want.best_cost));
                end
                results_checked++;
                recv_stall = receiver_steady ? 0 : $urandom_range(0, 11);
            end
            if (hold_results) begin
                stats_if.ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                stats_if.ready <= 1'b0;
            end else begin
                stats_if.ready <= 1'b1;
            end
        end
    end

    // long receiver hold while the sender keeps offering words
    initial begin : receiver_hold
        hold_results = 1'b0;
        while (!(words_accepted >= 300 && samples_to_send.size() > 20)) @(posedge i_clk);
        hold_results <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_results <= 1'b0;
    end

    initial begin : stimulus
        logic [CFG_BITS-1:0] sweep [8];
        logic [CFG_BITS-1:0] len_code;
        int unsigned         random_words;
        int unsigned         phase;
        int unsigned         k_eff;
        int unsigned         seqs;
        int unsigned         len;
        int unsigned         idx;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        sweep = '{7'd127, 7'd64, 7'd65, 7'd1, 7'd2, 7'd16, 7'd0, 7'd4};
        while (i_rst_n !== 1'b1) @(posedge i_clk);

        // window length from reset: rails, partial windows, then end of sequence
        @(negedge i_clk);
        push_word(16'h0000, 1'b0);
        push_word(16'hFFFF, 1'b0);
        push_word(16'h0000, 1'b0);
        push_word(16'hFFFF, 1'b0);
        push_word(16'hFFFF, 1'b0);
        push_word(16'h0000, 1'b0);
        push_word(16'hAAAA, 1'b0);
        push_word(16'h5555, 1'b0);
        push_word(16'hFFFF, 1'b0);
        push_word(16'h0000, 1'b1);
        wait_drained();

        // zero length acts as one
        write_window_length('0);
        @(negedge i_clk);
        push_word(16'hFFFF, 1'b0);
        push_word(16'h0000, 1'b0);
        push_word(16'h1234, 1'b1);
        wait_drained();

        // length grown and then shrunk inside one sequence
        write_window_length(7'd3);
        @(negedge i_clk);
        push_word(16'd5, 1'b0);
        push_word(16'd1, 1'b0);
        push_word(16'd9, 1'b0);
        wait_drained();
        write_window_length(7'd5);
        @(negedge i_clk);
        push_word(16'd7, 1'b0);
        push_word(16'd2, 1'b0);
        wait_drained();
        write_window_length(7'd2);
        @(negedge i_clk);
        push_word(16'hFFFF, 1'b1);
        wait_drained();

        random_words = 0;
        phase        = 0;
        while (random_words < RANDOM_WORDS) begin
            if (phase < 8) begin
                len_code = sweep[phase];
            end else begin
                case ($urandom_range(0, 9))
                    7:       len_code = CFG_BITS'($urandom_range(9, 40));
                    8:       len_code = $urandom_range(0, 1) ? '0
                                                             : CFG_BITS'($urandom_range(65, 127));
                    9:       len_code = CFG_BITS'($urandom_range(41, 64));
                    default: len_code = CFG_BITS'($urandom_range(1, 8));
                endcase
            end
            write_window_length(len_code);
            k_eff = clamp_window(len_code);
            @(negedge i_clk);
            sender_steady   = ($urandom_range(0, 3) == 0);
            receiver_steady = ($urandom_range(0, 3) == 0);
            seqs = (k_eff > 24) ? $urandom_range(1, 2) : $urandom_range(2, 6);
            for (idx = 0; idx < seqs; idx++) begin
                if ($urandom_range(0, 6) == 0) len = $urandom_range(1, k_eff);
                else len = k_eff + $urandom_range(0, 12);
                queue_sequence(len, (idx < seqs - 1) || ($urandom_range(0, 3) != 0));
                random_words += len;
            end
            phase++;
            wait_drained();
        end

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sliding_window_median_deviation.f */
design/swmd_pkg.sv
design/swmd_if.sv
design/swmd_cell.sv
design/sliding_window_median_deviation.sv
tb/tb_sliding_window_median_deviation.sv
